[hdl/tscz_pkg.sv]
package tscz_pkg;

	localparam int MAX_ITEMS = 4096;
	localparam int DATA_W = 32;
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W = DATA_W + 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_SORT_KEY,
		S_SORT_KEYD,
		S_SORT_CHK,
		S_SORT_CMP,
		S_SORT_PUT,
		S_INIT_RD,
		S_INIT_PIV,
		S_INIT_SUM,
		S_INIT_SET,
		S_PV_RD,
		S_PV_GET,
		S_PV_UP,
		S_PV_NEXT,
		S_SC_RD,
		S_SC_SUM,
		S_SC_UPD,
		S_EMIT
	} state_t;

endpackage

[hdl/tscz_in_if.sv]
interface tscz_in_if;
	import tscz_pkg::*;

	logic  valid;
	logic  ready;
	data_t value;
	logic  last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

[hdl/tscz_out_if.sv]
interface tscz_out_if;
	import tscz_pkg::*;

	logic    valid;
	logic    ready;
	data_t   low_value;
	data_t   mid_value;
	data_t   high_value;
	status_t status;

	modport source (output valid, output low_value, output mid_value, output high_value,
		output status, input ready);
	modport sink (input valid, input low_value, input mid_value, input high_value,
		input status, output ready);
endinterface

[hdl/tscz_ram.sv]
module tscz_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[hdl/three_sum_closest_to_zero_top.sv]
// Three-sum closest to zero.
// The items channel loads one signed word per cycle into a 4096-entry store;
// a word with last set closes the set. The block then sorts the store in place
// (insertion sort, a read state and a compare state per compare and move) and
// runs a two-pointer search for every pivot, a read, sum and update state per
// pointer step, since each step waits on the registered read of both pointer
// entries from the store. A zero sum ends the search early.
// A set of fewer than three words skips all of this and reports status 1.
// Words beyond the store size are dropped and the result carries status 2.
// The results channel delivers one word per set: the three chosen values in
// ascending order and the status. The result sits in an output register, so
// loading of the next set proceeds while the receiver stalls; only a new
// result waits for the previous one to be taken.
// Reset clears the word count, the overflow flag and all control state; the
// store itself needs no clearing since only entries written in the current set
// are read.
module three_sum_closest_to_zero_top (
	input  logic              clk,
	input  logic              arst_n,
	tscz_in_if.sink           items,
	tscz_out_if.source        results
);
	import tscz_pkg::*;

	state_t state_q, state_d;

	cnt_t  count_q;
	logic  ovf_q;
	cnt_t  n_q;
	status_t stat_q;
	cnt_t  i_q;
	cnt_t  j_q;
	data_t key_q;
	data_t piv_q;
	idx_t  lo_q;
	idx_t  hi_q;
	logic  phase_q;
	data_t best_a_q;
	data_t best_b_q;
	data_t best_c_q;
	logic [SUM_W-1:0] best_mag_q;
	logic signed [SUM_W-1:0] sum_s1;
	data_t va_s1;
	data_t vb_s1;

	logic  we;
	idx_t  waddr;
	data_t wdata;
	idx_t  raddr_a;
	idx_t  raddr_b;
	logic [DATA_W-1:0] rdata_a_raw;
	logic [DATA_W-1:0] rdata_b_raw;
	data_t ra;
	data_t rb;

	logic in_acc;
	logic out_free;
	cnt_t count_next;
	logic signed [SUM_W-1:0] sum_now;
	logic [SUM_W-1:0] mag;
	logic better;
	data_t s0, s1, s2, t0, t1, t2;

	tscz_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a_raw),
		.rdata_b (rdata_b_raw)
	);

	assign ra = data_t'(rdata_a_raw);
	assign rb = data_t'(rdata_b_raw);

	assign items.ready = (state_q == S_LOAD);
	assign in_acc = items.valid && items.ready;
	assign out_free = !results.valid || results.ready;
	assign count_next = (count_q < cnt_t'(MAX_ITEMS)) ? count_q + 1'b1 : count_q;

	assign sum_now = SUM_W'(ra) + SUM_W'(rb) + SUM_W'(piv_q);
	assign mag = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
	assign better = (mag < best_mag_q) || (sum_s1 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = items.value;
		raddr_a = '0;
		raddr_b = '0;
		unique case (state_q)
			S_LOAD: begin
				we = in_acc && (count_q < cnt_t'(MAX_ITEMS));
				if (in_acc && items.last) begin
					state_d = (count_next < cnt_t'(3)) ? S_EMIT : S_SORT_KEY;
				end
			end
			S_SORT_KEY: begin
				raddr_a = i_q[IDX_W-1:0];
				state_d = S_SORT_KEYD;
			end
			S_SORT_KEYD: state_d = S_SORT_CHK;
			S_SORT_CHK: begin
				raddr_a = IDX_W'(j_q - 1'b1);
				state_d = (j_q == '0) ? S_SORT_PUT : S_SORT_CMP;
			end
			S_SORT_CMP: begin
				if (ra > key_q) begin
					we = 1'b1;
					waddr = j_q[IDX_W-1:0];
					wdata = ra;
					state_d = S_SORT_CHK;
				end else begin
					state_d = S_SORT_PUT;
				end
			end
			S_SORT_PUT: begin
				we = 1'b1;
				waddr = j_q[IDX_W-1:0];
				wdata = key_q;
				state_d = ((i_q + 1'b1) < n_q) ? S_SORT_KEY : S_INIT_RD;
			end
			S_INIT_RD: begin
				raddr_a = IDX_W'(2);
				state_d = S_INIT_PIV;
			end
			S_INIT_PIV: begin
				raddr_a = IDX_W'(0);
				raddr_b = IDX_W'(1);
				state_d = S_INIT_SUM;
			end
			S_INIT_SUM: state_d = S_INIT_SET;
			S_INIT_SET: state_d = S_PV_RD;
			S_PV_RD: begin
				raddr_a = i_q[IDX_W-1:0];
				state_d = S_PV_GET;
			end
			S_PV_GET: state_d = (i_q >= cnt_t'(2)) ? S_SC_RD : S_PV_UP;
			S_PV_UP: state_d = ((i_q + cnt_t'(2)) < n_q) ? S_SC_RD : S_PV_NEXT;
			S_PV_NEXT: state_d = ((i_q + 1'b1) < n_q) ? S_PV_RD : S_EMIT;
			S_SC_RD: begin
				raddr_a = lo_q;
				raddr_b = hi_q;
				if (lo_q < hi_q) begin
					state_d = S_SC_SUM;
				end else begin
					state_d = phase_q ? S_PV_NEXT : S_PV_UP;
				end
			end
			S_SC_SUM: state_d = S_SC_UPD;
			S_SC_UPD: state_d = (sum_s1 == '0) ? S_EMIT : S_SC_RD;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_acc) begin
			if (items.last) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				count_q <= count_next;
				if (count_q == cnt_t'(MAX_ITEMS)) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers; they hold no control meaning across sets.
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				if (in_acc && items.last) begin
					n_q <= count_next;
					i_q <= cnt_t'(1);
					if (count_next < cnt_t'(3)) begin
						stat_q <= ST_SHORT;
						best_a_q <= '0;
						best_b_q <= '0;
						best_c_q <= '0;
					end else if (ovf_q || (count_q == cnt_t'(MAX_ITEMS))) begin
						stat_q <= ST_OVERFLOW;
					end else begin
						stat_q <= ST_OK;
					end
				end
			end
			S_SORT_KEYD: begin
				key_q <= ra;
				j_q <= i_q;
			end
			S_SORT_CMP: begin
				if (ra > key_q) begin
					j_q <= j_q - 1'b1;
				end
			end
			S_SORT_PUT: i_q <= i_q + 1'b1;
			S_INIT_PIV: piv_q <= ra;
			S_INIT_SUM: begin
				sum_s1 <= sum_now;
				best_a_q <= ra;
				best_b_q <= rb;
				best_c_q <= piv_q;
			end
			S_INIT_SET: begin
				best_mag_q <= mag;
				i_q <= '0;
			end
			S_PV_GET: begin
				piv_q <= ra;
				lo_q <= '0;
				hi_q <= IDX_W'(i_q - 1'b1);
				phase_q <= 1'b0;
			end
			S_PV_UP: begin
				lo_q <= IDX_W'(i_q + 1'b1);
				hi_q <= IDX_W'(n_q - 1'b1);
				phase_q <= 1'b1;
			end
			S_PV_NEXT: i_q <= i_q + 1'b1;
			S_SC_SUM: begin
				sum_s1 <= sum_now;
				va_s1 <= ra;
				vb_s1 <= rb;
			end
			S_SC_UPD: begin
				if (better) begin
					best_a_q <= va_s1;
					best_b_q <= vb_s1;
					best_c_q <= piv_q;
					best_mag_q <= mag;
				end
				if (sum_s1 > 0) begin
					hi_q <= hi_q - 1'b1;
				end else begin
					lo_q <= lo_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Three-element sorting network for the emitted word.
	always_comb begin
		s0 = best_a_q;
		s1 = best_b_q;
		s2 = best_c_q;
		if (s0 > s1) begin
			t0 = s1;
			t1 = s0;
		end else begin
			t0 = s0;
			t1 = s1;
		end
		if (t1 > s2) begin
			t2 = t1;
			t1 = s2;
		end else begin
			t2 = s2;
		end
		if (t0 > t1) begin
			s0 = t1;
			s1 = t0;
		end else begin
			s0 = t0;
			s1 = t1;
		end
		s2 = t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			results.valid <= 1'b1;
		end else if (results.ready) begin
			results.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			results.low_value <= s0;
			results.mid_value <= s1;
			results.high_value <= s2;
			results.status <= stat_q;
		end
	end

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SC_SUM |-> lo_q < hi_q)
		else $error("scan step with crossed pointers");

	a_sort_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SORT_CMP |-> j_q <= i_q && j_q != '0)
		else $error("sort index out of range");

	a_ok_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status != ST_SHORT |->
		results.low_value <= results.mid_value && results.mid_value <= results.high_value)
		else $error("result values not ascending");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_free |=> state_q == S_LOAD && results.valid)
		else $error("result not presented after emit");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	import tscz_pkg::*;

	typedef struct {
		data_t   low_value;
		data_t   mid_value;
		data_t   high_value;
		status_t status;
	} trio_t;

	logic clk;
	logic arst_n;

	tscz_in_if  items ();
	tscz_out_if results ();

	three_sum_closest_to_zero_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items.sink),
		.results (results.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Own copy of the block's state for prediction.
	data_t  set_store [MAX_ITEMS];
	int     set_count;
	bit     set_overflow;
	longint best_mag;
	int     best_a;
	int     best_b;
	data_t  best_pivot;

	trio_t  expected_trios [$];
	int     error_count;
	int     words_sent;
	int     trios_seen;
	bit     quiet;
	int     ready_wait;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic longint magnitude(input longint s);
		return (s < 0) ? -s : s;
	endfunction

	function automatic bit pointer_scan(input int lo, input int hi, input data_t pivot);
		longint s;
		longint m;
		while (lo < hi) begin
			s = longint'(set_store[lo]) + longint'(set_store[hi]) + longint'(pivot);
			m = magnitude(s);
			if (m < best_mag || s == 0) begin
				best_a = lo;
				best_b = hi;
				best_pivot = pivot;
				best_mag = m;
			end
			if (s == 0)
				return 1'b1;
			if (s > 0)
				hi--;
			else
				lo++;
		end
		return 1'b0;
	endfunction

	function automatic void find_closest(input int n);
		data_t key;
		int j;
		for (int i = 1; i < n; i++) begin
			key = set_store[i];
			j = i;
			while (j > 0 && set_store[j-1] > key) begin
				set_store[j] = set_store[j-1];
				j--;
			end
			set_store[j] = key;
		end
		best_a = 0;
		best_b = 1;
		best_pivot = set_store[2];
		best_mag = magnitude(longint'(set_store[0]) + longint'(set_store[1])
			+ longint'(set_store[2]));
		for (int i = 0; i < n; i++) begin
			if (i >= 2 && pointer_scan(0, i - 1, set_store[i]))
				return;
			if (i + 2 < n && pointer_scan(i + 1, n - 1, set_store[i]))
				return;
		end
	endfunction

	// Applies one accepted word to the predicted state.
	function automatic void predict_word(input data_t v, input bit l);
		trio_t t;
		data_t a, b, c, x;
		if (set_count < MAX_ITEMS) begin
			set_store[set_count] = v;
			set_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (!l)
			return;
		if (set_count < 3) begin
			a = '0;
			b = '0;
			c = '0;
			t.status = ST_SHORT;
		end else begin
			find_closest(set_count);
			a = set_store[best_a];
			b = set_store[best_b];
			c = best_pivot;
			if (a > b) begin x = a; a = b; b = x; end
			if (b > c) begin x = b; b = c; c = x; end
			if (a > b) begin x = a; a = b; b = x; end
			t.status = set_overflow ? ST_OVERFLOW : ST_OK;
		end
		t.low_value = a;
		t.mid_value = b;
		t.high_value = c;
		expected_trios = {expected_trios, t};
		set_count = 0;
		set_overflow = 1'b0;
	endfunction

	task automatic send_word(input data_t v, input bit l);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.value <= v;
		items.last <= l;
		do @(posedge clk); while (!items.ready);
		predict_word(v, l);
		words_sent++;
	endtask

	task automatic send_set(input data_t vals [$]);
		foreach (vals[i])
			send_word(vals[i], i == vals.size() - 1);
	endtask

	function automatic data_t draw_value(input int kind);
		case (kind)
			0: return data_t'($urandom());
			1: return data_t'($urandom_range(0, 40)) - 20;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return data_t'($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	// Checks each word taken from the results channel and paces ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready) begin
				trios_seen++;
				if (expected_trios.size() == 0) begin
					report_mismatch("result word with none expected");
				end else begin
					trio_t e;
					e = expected_trios.pop_front();
					if (results.low_value !== e.low_value)
						report_mismatch($sformatf("low_value %0d, expected %0d",
							results.low_value, e.low_value));
					if (results.mid_value !== e.mid_value)
						report_mismatch($sformatf("mid_value %0d, expected %0d",
							results.mid_value, e.mid_value));
					if (results.high_value !== e.high_value)
						report_mismatch($sformatf("high_value %0d, expected %0d",
							results.high_value, e.high_value));
					if (results.status !== e.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							results.status, e.status));
				end
				ready_wait = quiet ? 0 : $urandom_range(0, 5);
			end
			if (ready_wait > 0) begin
				results.ready <= 1'b0;
				ready_wait--;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	task automatic test_short_sets();
		send_set('{data_t'(7)});
		send_set('{data_t'(-3), data_t'(5)});
	endtask

	task automatic test_extremes();
		send_set('{32'sh80000000, 32'sh80000000, 32'sh80000000});
		send_set('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
		send_set('{32'sh7fffffff, 32'sh80000000, data_t'(-1), data_t'(0), 32'sh7fffffff});
	endtask

	task automatic test_zero_sum();
		send_set('{data_t'(9), data_t'(-4), data_t'(1), data_t'(-5), data_t'(3), data_t'(12)});
		send_set('{data_t'(5), data_t'(5), data_t'(5), data_t'(1)});
	endtask

	// One word past the store's size; ascending words keep the sort short.
	task automatic test_overflow();
		for (int k = 0; k <= MAX_ITEMS; k++)
			send_word(data_t'(k - 2048), k == MAX_ITEMS);
	endtask

	task automatic test_random();
		data_t vals [$];
		int n;
		int kind;
		int r;
		while (words_sent < 950 + MAX_ITEMS + 1 + 20) begin
			if ($urandom_range(0, 19) == 0)
				quiet = !quiet;
			r = $urandom_range(0, 9);
			n = (r == 0) ? $urandom_range(1, 2) : (r == 1) ? $urandom_range(13, 40)
				: $urandom_range(3, 12);
			kind = $urandom_range(0, 3);
			vals.delete();
			repeat (n)
				vals = {vals, draw_value($urandom_range(0, 4) == 0 ? 0 : kind)};
			send_set(vals);
		end
		quiet = 1'b0;
	endtask

	initial begin
		int settle;
		arst_n = 1'b0;
		items.valid = 1'b0;
		items.value = '0;
		items.last = 1'b0;
		results.ready = 1'b0;
		error_count = 0;
		words_sent = 0;
		trios_seen = 0;
		set_count = 0;
		set_overflow = 1'b0;
		quiet = 1'b0;
		ready_wait = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_sets();
		test_extremes();
		test_zero_sum();
		test_overflow();
		test_random();
		items.valid <= 1'b0;
		while (expected_trios.size() != 0)
			@(posedge clk);
		settle = 200;
		repeat (settle) @(posedge clk);
		$display("Sent %0d words in sets of 1 to %0d, checked %0d result words.",
			words_sent, MAX_ITEMS + 1, trios_seen);
		if (error_count == 0)
			$display("three_sum_closest_to_zero_top: match");
		else
			$display("three_sum_closest_to_zero_top: mismatch");
		$finish;
	end

	initial begin
		#50000000;
		$display("Timed out with %0d results outstanding.", expected_trios.size());
		$display("three_sum_closest_to_zero_top: mismatch");
		$finish;
	end

endmodule
